/* rtl/itoa_pkg.sv */
// Shared types, constants and helpers for the radix-to-ASCII converter.
`default_nettype none
package itoa_pkg;

    // Number of hex digits printed in the fixed-width hex mode.
    localparam int HEX_DIGITS = 8;
    // Longest character sequence that one number can produce.
    localparam int MAX_CHARS  = 12;
    // Decimal digits needed for a 32-bit magnitude.
    localparam int NUM_DEC    = 10;
    // Digit count actually emitted in fixed hex mode, held to 1..MAX_CHARS.
    localparam int HEX_COUNT  = (HEX_DIGITS > MAX_CHARS) ? MAX_CHARS :
                                (HEX_DIGITS < 1) ? 1 : HEX_DIGITS;

    localparam logic [1:0] MODE_DEC     = 2'd0;
    localparam logic [1:0] MODE_OCT     = 2'd1;
    localparam logic [1:0] MODE_HEX_MIN = 2'd2;
    localparam logic [1:0] MODE_HEX_FIX = 2'd3;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ALPHA = 8'h37;

    // Reciprocal of ten for the multiply-and-shift divide.
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    // One number as it moves down the pipeline.
    typedef struct packed {
        logic [31:0]             raw;
        logic [1:0]              mode;
        logic                    neg;
        logic [31:0]             mag;
        logic [31:0]             quo;
        logic [NUM_DEC-1:0][3:0] dig;
    } t_item;

    // Map a digit value to its uppercase ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_ALPHA + {4'd0, d};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/itoa_digit.sv */
// One pipeline stage that peels off the next decimal digit.
`default_nettype none
module itoa_digit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire itoa_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output itoa_pkg::t_item     o_item
);
    import itoa_pkg::*;

    logic        r_v;
    t_item       r_item;
    t_item       n_item;
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] q10;
    logic [31:0] rem;

    // Divide the running quotient by ten with a reciprocal multiply.
    always_comb begin
        prod = 64'(i_item.quo) * 64'(RECIP_TEN);
        q    = {3'd0, prod[63:35]};
        q10  = (q << 3) + (q << 1);
        rem  = i_item.quo - q10;
        n_item     = i_item;
        n_item.quo = q;
        n_item.dig = {rem[3:0], i_item.dig[NUM_DEC-1:1]};
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    // Stage register; holds while the next stage is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/itoa_out.sv */
// Formats the digits of one number and sends them out one character a cycle while the receiver is ready.
`default_nettype none
module itoa_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire itoa_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_char_out,
    output logic                 o_last
);
    import itoa_pkg::*;

    logic                      r_v;
    logic [MAX_CHARS-1:0][3:0] r_d;
    logic [3:0]                r_idx;
    logic                      r_sign;

    logic [MAX_CHARS-1:0][3:0] n_d;
    logic [3:0]                n_idx;
    logic                      n_sign;
    logic [32:0]               mag33;
    logic [47:0]               ext;
    logic                      fire;

    // Build the digit list, least significant first, and the index of its top digit.
    always_comb begin
        mag33 = {1'b0, i_item.mag};
        ext   = {{16{i_item.raw[31]}}, i_item.raw};
        n_d   = '0;
        case (i_item.mode)
            MODE_DEC: begin
                for (int i = 0; i < NUM_DEC; i++) begin
                    n_d[i] = i_item.dig[i];
                end
            end
            MODE_OCT: begin
                for (int i = 0; i < 11; i++) begin
                    n_d[i] = {1'b0, mag33[3*i +: 3]};
                end
            end
            MODE_HEX_MIN: begin
                for (int i = 0; i < 8; i++) begin
                    n_d[i] = i_item.mag[4*i +: 4];
                end
            end
            default: begin
                for (int i = 0; i < MAX_CHARS; i++) begin
                    n_d[i] = ext[4*i +: 4];
                end
            end
        endcase
        n_idx = 4'd0;
        for (int i = 1; i < MAX_CHARS; i++) begin
            if (n_d[i] != 4'd0) begin
                n_idx = 4'(i);
            end
        end
        if (i_item.mode == MODE_HEX_FIX) begin
            n_idx = 4'(HEX_COUNT - 1);
        end
        n_sign = i_item.neg;
    end

    assign o_valid    = r_v;
    assign o_last     = !r_sign && (r_idx == 4'd0);
    assign o_char_out = r_sign ? CHAR_MINUS : digit_char(r_d[r_idx]);
    assign fire       = r_v && i_ready;
    assign o_ready    = !r_v || (i_ready && o_last);

    // Character counter: sign first, then digits from the top down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_d    <= n_d;
            r_idx  <= n_idx;
            r_sign <= n_sign;
        end else if (fire) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_idx != 4'd0) begin
                r_idx <= r_idx - 4'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII radix converter.
//
// Converts a 32-bit signed number to ASCII in decimal, octal, minimal hex or
// fixed-width hex, one character per output transaction, most significant
// first, with the final character flagged by o_last. A new number may enter
// every cycle while the pipeline is not stalled; it passes a sign stage, ten
// decimal-digit stages (one reciprocal multiply each) and a formatter, each
// registered. Throughput is set by the output: a number holds the output
// until all of its characters (1 to 12) have been taken, and the pipeline
// stalls behind it without losing anything.
`default_nettype none
module integer_to_ascii_radix (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value,
    input  wire logic [1:0]  i_mode,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_char_out,
    output logic             o_last
);
    import itoa_pkg::*;

    logic  s_v   [0:NUM_DEC];
    logic  s_rdy [0:NUM_DEC];
    t_item s_item[0:NUM_DEC];

    logic  r_v;
    t_item r_item;
    t_item n_item;

    // Sign stage: take the magnitude for the signed modes.
    always_comb begin
        n_item      = '0;
        n_item.raw  = i_value;
        n_item.mode = i_mode;
        n_item.neg  = i_value[31] && (i_mode != MODE_HEX_FIX);
        n_item.mag  = i_value[31] ? (32'd0 - i_value) : i_value;
        n_item.quo  = n_item.mag;
    end

    assign o_ready   = !r_v || s_rdy[0];
    assign s_v[0]    = r_v;
    assign s_item[0] = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    // Decimal digit stages.
    for (genvar k = 0; k < NUM_DEC; k++) begin : g_dig
        itoa_digit u_dig (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[k]),
            .o_ready (s_rdy[k]),
            .i_item  (s_item[k]),
            .o_valid (s_v[k+1]),
            .i_ready (s_rdy[k+1]),
            .o_item  (s_item[k+1])
        );
    end

    // Formatter and character output.
    itoa_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_v[NUM_DEC]),
        .o_ready    (s_rdy[NUM_DEC]),
        .i_item     (s_item[NUM_DEC]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

/* rtl/itoa_checker.sv */
// Port-level checks for the integer to ASCII radix converter.
`default_nettype none
module itoa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_char_out,
    input wire logic       o_last
);
    import itoa_pkg::*;

    // A stalled output transaction holds its character.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_out) && $stable(o_last))
        else $error("output changed while stalled");

    // Every character is a digit, an uppercase hex letter or a minus sign.
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_out >= 8'h30 && o_char_out <= 8'h39) ||
                     (o_char_out >= 8'h41 && o_char_out <= 8'h46) ||
                     o_char_out == CHAR_MINUS))
        else $error("illegal character");

    // A minus sign is never the final character.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_out == CHAR_MINUS |-> !o_last)
        else $error("minus sign flagged last");

    // Within a number the next character follows at once and is a digit.
    a_digit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_char_out != CHAR_MINUS)
        else $error("bad character after a non-final one");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);
`default_nettype wire
